// File: hw/rtl/bdq_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bdq_pkg: shared types and constants of the bounded deque
// Operation codes, controller states, command and status bundles, and field
// widths used by the controller, the datapath and the top level.
// ----------------------------------------------------------------------------
package bdq_pkg;

  // field widths
  localparam int unsigned DataW = 32;
  localparam int unsigned CntW  = 11;
  localparam int unsigned OpW   = 3;

  // capacity register after reset
  localparam logic [CntW-1:0] CapReset = 11'd1024;

  // operation codes
  typedef enum logic [OpW-1:0] {
    OP_QUERY     = 3'd0,
    OP_INS_FRONT = 3'd1,
    OP_INS_BACK  = 3'd2,
    OP_DEL_FRONT = 3'd3,
    OP_DEL_BACK  = 3'd4
  } op_e;

  // controller states
  typedef enum logic [1:0] {
    S_IDLE   = 2'd0,
    S_UPDATE = 2'd1,
    S_READ   = 2'd2,
    S_LOAD   = 2'd3
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic accept;  // capture the incoming word
    logic update;  // apply the operation to pointers and store
    logic rd;      // read front and rear entries
    logic load;    // load the output register
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic out_free;  // output register can take a new word this cycle
  } sts_t;

endpackage

`default_nettype wire

// File: hw/rtl/bdq_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bdq_ctrl: deque sequencer
// Steps one word through capture, update, entry read and output load, and
// drives the input stall.
// ----------------------------------------------------------------------------
module bdq_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_stall_o,
  input  bdq_pkg::sts_t      sts_i,
  output bdq_pkg::cmd_t      cmd_o
);

  bdq_pkg::state_e state_q, state_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bdq_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state and commands
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      bdq_pkg::S_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = bdq_pkg::S_UPDATE;
        end
      end
      bdq_pkg::S_UPDATE: begin
        cmd_o.update = 1'b1;
        state_d      = bdq_pkg::S_READ;
      end
      bdq_pkg::S_READ: begin
        cmd_o.rd = 1'b1;
        state_d  = bdq_pkg::S_LOAD;
      end
      bdq_pkg::S_LOAD: begin
        if (sts_i.out_free) begin
          cmd_o.load = 1'b1;
          state_d    = bdq_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = bdq_pkg::S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// File: hw/rtl/bdq_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bdq_datapath: deque pointers, ring store and output register
// Holds head pointer, count and capacity, the entry memory with one write
// and two registered read ports, and the result register.
// ----------------------------------------------------------------------------
module bdq_datapath #(
  parameter int unsigned DEPTH = 1024
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  bdq_pkg::cmd_t                     cmd_i,
  output bdq_pkg::sts_t                     sts_o,
  input  wire logic [bdq_pkg::OpW-1:0]      operation_i,
  input  wire logic [bdq_pkg::DataW-1:0]    value_i,
  input  wire logic                         cfg_we_i,
  input  wire logic [bdq_pkg::CntW-1:0]     cfg_wdata_i,
  output logic                              out_valid_o,
  input  wire logic                         out_stall_i,
  output logic                              ok_o,
  output logic                              empty_res_o,
  output logic                              full_res_o,
  output logic [bdq_pkg::CntW-1:0]          count_o,
  output logic [bdq_pkg::DataW-1:0]         front_value_o,
  output logic [bdq_pkg::DataW-1:0]         rear_value_o
);

  localparam int unsigned AW     = $clog2(DEPTH);
  localparam int unsigned CntW   = bdq_pkg::CntW;
  localparam int unsigned DataW  = bdq_pkg::DataW;
  localparam int unsigned SW     = ((AW > CntW) ? AW : CntW) + 1;
  localparam int unsigned CntMax = (1 << CntW) - 1;
  localparam logic [SW-1:0]   DepthS = SW'(DEPTH);
  localparam logic [AW-1:0]   LastIdx = AW'(DEPTH - 1);
  localparam logic [CntW-1:0] CapLim = CntW'((DEPTH > CntMax) ? CntMax : DEPTH);

  // captured word
  bdq_pkg::op_e       op_q;
  logic [DataW-1:0]   value_q;

  // deque state
  logic [AW-1:0]      head_q, head_d;
  logic [CntW-1:0]    cnt_q, cnt_d;
  logic [CntW-1:0]    cap_q;
  logic               ok_q, ok_d;

  // ring store
  logic [DataW-1:0]   mem_q [DEPTH];
  logic [DataW-1:0]   rd_front_q, rd_rear_q;
  logic               mem_we;
  logic [AW-1:0]      wr_addr;
  logic [AW-1:0]      rear_addr;

  // result register
  logic               out_valid_q;
  logic               res_ok_q, res_empty_q, res_full_q;
  logic [CntW-1:0]    res_cnt_q;
  logic [DataW-1:0]   res_front_q, res_rear_q;

  logic [CntW-1:0]    eff_cap;
  logic               has_room;
  logic [AW-1:0]      head_dec, head_inc;
  logic [SW-1:0]      back_sum, rear_sum;
  logic [AW-1:0]      back_addr;
  logic [CntW-1:0]    rear_off;
  logic               cnt_zero;

  // effective capacity saturates at the store depth
  assign eff_cap  = (cap_q > CapLim) ? CapLim : cap_q;
  assign has_room = cnt_q < eff_cap;
  assign cnt_zero = (cnt_q == '0);

  // ring pointer arithmetic
  assign head_dec  = (head_q == '0) ? LastIdx : head_q - AW'(1);
  assign head_inc  = (head_q == LastIdx) ? '0 : head_q + AW'(1);
  assign back_sum  = SW'(head_q) + SW'(cnt_q);
  assign back_addr = (back_sum >= DepthS) ? AW'(back_sum - DepthS) : AW'(back_sum);
  assign rear_off  = cnt_q - CntW'(1);
  assign rear_sum  = SW'(head_q) + SW'(rear_off);
  assign rear_addr = (rear_sum >= DepthS) ? AW'(rear_sum - DepthS) : AW'(rear_sum);

  // operation decode
  always_comb begin
    head_d  = head_q;
    cnt_d   = cnt_q;
    ok_d    = 1'b1;
    mem_we  = 1'b0;
    wr_addr = back_addr;
    case (op_q)
      bdq_pkg::OP_INS_FRONT: begin
        if (has_room) begin
          head_d  = head_dec;
          cnt_d   = cnt_q + CntW'(1);
          mem_we  = 1'b1;
          wr_addr = head_dec;
        end else begin
          ok_d = 1'b0;
        end
      end
      bdq_pkg::OP_INS_BACK: begin
        if (has_room) begin
          cnt_d  = cnt_q + CntW'(1);
          mem_we = 1'b1;
        end else begin
          ok_d = 1'b0;
        end
      end
      bdq_pkg::OP_DEL_FRONT: begin
        if (!cnt_zero) begin
          head_d = head_inc;
          cnt_d  = cnt_q - CntW'(1);
        end else begin
          ok_d = 1'b0;
        end
      end
      bdq_pkg::OP_DEL_BACK: begin
        if (!cnt_zero) begin
          cnt_d = cnt_q - CntW'(1);
        end else begin
          ok_d = 1'b0;
        end
      end
      default: begin
        // query and unused codes leave the state alone
      end
    endcase
  end

  // captured word
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      op_q    <= bdq_pkg::op_e'(operation_i);
      value_q <= value_i;
    end
  end

  // pointers, count and capacity
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
      cnt_q  <= '0;
      ok_q   <= 1'b0;
      cap_q  <= bdq_pkg::CapReset;
    end else begin
      if (cmd_i.update) begin
        head_q <= head_d;
        cnt_q  <= cnt_d;
        ok_q   <= ok_d;
      end
      if (cfg_we_i) begin
        cap_q <= cfg_wdata_i;
      end
    end
  end

  // ring store: one write port, front and rear read ports
  always_ff @(posedge clk_i) begin
    if (cmd_i.update && mem_we) begin
      mem_q[wr_addr] <= value_q;
    end
    if (cmd_i.rd) begin
      rd_front_q <= mem_q[head_q];
      rd_rear_q  <= mem_q[rear_addr];
    end
  end

  // output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // output payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      res_ok_q    <= ok_q;
      res_empty_q <= cnt_zero;
      res_full_q  <= (cnt_q >= eff_cap);
      res_cnt_q   <= cnt_q;
      res_front_q <= cnt_zero ? '1 : rd_front_q;
      res_rear_q  <= cnt_zero ? '1 : rd_rear_q;
    end
  end

  assign sts_o.out_free = !out_valid_q || !out_stall_i;

  assign out_valid_o   = out_valid_q;
  assign ok_o          = res_ok_q;
  assign empty_res_o   = res_empty_q;
  assign full_res_o    = res_full_q;
  assign count_o       = res_cnt_q;
  assign front_value_o = res_front_q;
  assign rear_value_o  = res_rear_q;

endmodule

`default_nettype wire

// File: hw/rtl/bounded_double_ended_queue_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bounded_double_ended_queue_unit: bounded deque of signed 32-bit values
// Insert and delete at either end of a ring store, one result per word.
// ----------------------------------------------------------------------------
// Each input word steps from acceptance to a loaded result through capture,
// update of head and count with the single store write, a read of front and
// rear through the store's two registered read ports, and the output load.
// The next word is accepted in the cycle after the load, even while the
// previous result still waits in the output register, so a new word is taken
// only once the last one is through; a stalled output holds the load while the
// output register is occupied. The store needs no clearing after reset. The
// user must write capacity through cfg_we_i/cfg_wdata_i only while the unit is
// idle; the block does not enforce this. Values above DEPTH act as DEPTH.
module bounded_double_ended_queue_unit #(
  parameter int unsigned DEPTH = 1024
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         in_valid_i,
  output logic                              in_stall_o,
  input  wire logic [bdq_pkg::OpW-1:0]      operation_i,
  input  wire logic signed [bdq_pkg::DataW-1:0] value_i,
  output logic                              out_valid_o,
  input  wire logic                         out_stall_i,
  output logic                              ok_o,
  output logic                              empty_res_o,
  output logic                              full_res_o,
  output logic [bdq_pkg::CntW-1:0]          count_o,
  output logic signed [bdq_pkg::DataW-1:0]  front_value_o,
  output logic signed [bdq_pkg::DataW-1:0]  rear_value_o,
  input  wire logic                         cfg_we_i,
  input  wire logic [bdq_pkg::CntW-1:0]     cfg_wdata_i
);

  bdq_pkg::cmd_t cmd;
  bdq_pkg::sts_t sts;

  // sequencer
  bdq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // pointers, store and result register
  bdq_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .operation_i   (operation_i),
    .value_i       (value_i),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .ok_o          (ok_o),
    .empty_res_o   (empty_res_o),
    .full_res_o    (full_res_o),
    .count_o       (count_o),
    .front_value_o (front_value_o),
    .rear_value_o  (rear_value_o)
  );

  // empty deque reports all ones at both ends
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && empty_res_o) |-> (front_value_o == '1 && rear_value_o == '1))
    else $error("empty result does not report -1 at front and rear");

  // empty flag agrees with the count
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (empty_res_o == (count_o == '0)))
    else $error("empty flag disagrees with count");

  // count never exceeds the store depth
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ({21'd0, count_o} <= 32'(DEPTH)))
    else $error("count exceeds store depth");

  // an accepted word keeps the input stalled while it is processed
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input accepted while a word is in progress");

endmodule

`default_nettype wire

// File: test/testbench.sv
// ----------------------------------------------------------------------------
// testbench: self-checking bench for bounded_double_ended_queue_unit
// Drives front and back inserts and deletes, queries and spare operation
// codes under many capacity settings, with bursty input and a stalling
// output. A tracker class mirrors the ring, head and count, and checks every
// result word, field by field, against the oldest expected view.
// ----------------------------------------------------------------------------
module testbench;

  localparam int unsigned RING_DEPTH   = 1024;
  localparam int unsigned RANDOM_WORDS = 330;
  localparam int unsigned IDLE_LIMIT   = 2000;
  localparam int unsigned DRAIN_CYCLES = 8;

  // codes outside op_e, treated as a plain query
  localparam logic [bdq_pkg::OpW-1:0]  OP_SPARE_FIRST = 3'd5;
  localparam logic [bdq_pkg::OpW-1:0]  OP_SPARE_LAST  = 3'd7;
  localparam logic [bdq_pkg::CntW-1:0] CAP_ALL_ONES   = 11'd2047;

  // deque state as seen in one result word
  typedef struct packed {
    logic                      ok;
    logic                      empty;
    logic                      full;
    logic [bdq_pkg::CntW-1:0]  count;
    logic [bdq_pkg::DataW-1:0] front;
    logic [bdq_pkg::DataW-1:0] rear;
  } deque_view_t;

  // mirror of the deque plus the views still owed by the block
  class deque_tracker;
    logic [bdq_pkg::DataW-1:0] ring [RING_DEPTH];
    int unsigned      head;
    int unsigned      held;
    int unsigned      cap;
    deque_view_t      expected_views[$];
    int unsigned      words;
    int unsigned      checked;
    int unsigned      errors;
    int unsigned      refused;
    int unsigned      peak;

    function new();
      head    = 0;
      held    = 0;
      cap     = bdq_pkg::CapReset;
      words   = 0;
      checked = 0;
      errors  = 0;
      refused = 0;
      peak    = 0;
    endfunction

    function void set_capacity(int unsigned c);
      cap = c;
    endfunction

    // apply one accepted word and queue the view it should produce
    function void note_word(logic [bdq_pkg::OpW-1:0] op, logic [bdq_pkg::DataW-1:0] v);
      int unsigned limit;
      deque_view_t view;
      limit   = (cap > RING_DEPTH) ? RING_DEPTH : cap;
      view.ok = 1'b1;
      case (op)
        bdq_pkg::OP_INS_FRONT: begin
          if (held < limit) begin
            head       = (head == 0) ? RING_DEPTH - 1 : head - 1;
            ring[head] = v;
            held++;
          end else begin
            view.ok = 1'b0;
          end
        end
        bdq_pkg::OP_INS_BACK: begin
          if (held < limit) begin
            ring[(head + held) % RING_DEPTH] = v;
            held++;
          end else begin
            view.ok = 1'b0;
          end
        end
        bdq_pkg::OP_DEL_FRONT: begin
          if (held != 0) begin
            head = (head + 1) % RING_DEPTH;
            held--;
          end else begin
            view.ok = 1'b0;
          end
        end
        bdq_pkg::OP_DEL_BACK: begin
          if (held != 0) held--;
          else view.ok = 1'b0;
        end
        default: ;
      endcase
      view.empty = (held == 0);
      view.full  = (held >= limit);
      view.count = held[bdq_pkg::CntW-1:0];
      // an empty deque shows all ones at both ends
      if (held == 0) begin
        view.front = '1;
        view.rear  = '1;
      end else begin
        view.front = ring[head];
        view.rear  = ring[(head + held - 1) % RING_DEPTH];
      end
      words++;
      if (!view.ok) refused++;
      if (held > peak) peak = held;
      expected_views = {expected_views, view};
    endfunction

    function void check_field(string name, logic [bdq_pkg::DataW-1:0] want,
                              logic [bdq_pkg::DataW-1:0] got);
      if (got !== want) begin
        $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
        errors++;
      end
    endfunction

    // compare one result word with the oldest expected view
    function void check_word(deque_view_t got);
      deque_view_t want;
      if (expected_views.size() == 0) begin
        $display("%0t: result word with nothing outstanding: expected none, actual %h",
                 $time, got);
        errors++;
      end else begin
        want = expected_views[0];
        expected_views.delete(0);
        checked++;
        check_field("ok", want.ok, got.ok);
        check_field("empty_res", want.empty, got.empty);
        check_field("full_res", want.full, got.full);
        check_field("count", want.count, got.count);
        check_field("front_value", want.front, got.front);
        check_field("rear_value", want.rear, got.rear);
      end
    endfunction
  endclass

  logic                             clk_i       = 1'b0;
  logic                             rst_ni      = 1'b0;
  logic                             in_valid_i  = 1'b0;
  logic [bdq_pkg::OpW-1:0]          operation_i = '0;
  logic signed [bdq_pkg::DataW-1:0] value_i     = '0;
  logic                             out_stall_i = 1'b0;
  logic                             cfg_we_i    = 1'b0;
  logic [bdq_pkg::CntW-1:0]         cfg_wdata_i = '0;
  logic                             in_stall_o;
  logic                             out_valid_o;
  logic                             ok_o;
  logic                             empty_res_o;
  logic                             full_res_o;
  logic [bdq_pkg::CntW-1:0]         count_o;
  logic signed [bdq_pkg::DataW-1:0] front_value_o;
  logic signed [bdq_pkg::DataW-1:0] rear_value_o;

  deque_tracker tracker = new();

  bounded_double_ended_queue_unit dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .operation_i  (operation_i),
    .value_i      (value_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .ok_o         (ok_o),
    .empty_res_o  (empty_res_o),
    .full_res_o   (full_res_o),
    .count_o      (count_o),
    .front_value_o(front_value_o),
    .rear_value_o (rear_value_o),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i)
  );

  always #5 clk_i = ~clk_i;

  // result monitor
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      tracker.check_word(deque_view_t'{ok_o, empty_res_o, full_res_o, count_o,
                                       front_value_o, rear_value_o});
    end
  end

  // output stall pattern, switching between four styles at random
  int unsigned stall_mode = 0;
  int unsigned stall_left = 0;
  always @(posedge clk_i) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_left = $urandom_range(20, 120);
    end else begin
      stall_left--;
    end
    case (stall_mode)
      0: out_stall_i <= 1'b0;
      1: out_stall_i <= ($urandom_range(0, 3) == 0);
      2: out_stall_i <= ($urandom_range(0, 9) < 6);
      default: out_stall_i <= ((stall_left % 7) < 3);
    endcase
  end

  // watchdog on cycles without any handshake
  int unsigned quiet_cycles = 0;
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= IDLE_LIMIT) begin
        $display("%0t: no handshake for %0d cycles", $time, quiet_cycles);
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  // sender burst state
  int unsigned burst_left  = 0;
  bit          steady_send = 1'b0;

  // present one word, with a random gap at burst boundaries unless sending steadily
  task automatic send_word(logic [bdq_pkg::OpW-1:0] op, logic [bdq_pkg::DataW-1:0] v);
    int unsigned gap = 0;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      if (!steady_send) gap = $urandom_range(0, 5);
    end
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    operation_i <= op;
    value_i     <= v;
    do @(posedge clk_i); while (in_stall_o);
    tracker.note_word(op, v);
    burst_left--;
  endtask

  // write capacity once every result is back and the pipe has settled
  task automatic write_capacity(logic [bdq_pkg::CntW-1:0] c);
    in_valid_i <= 1'b0;
    while (tracker.expected_views.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= c;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    tracker.set_capacity(c);
    burst_left = 0;
  endtask

  // values lean on the sign and all-ones extremes
  function automatic logic [bdq_pkg::DataW-1:0] pick_value();
    logic [bdq_pkg::DataW-1:0] v;
    case ($urandom_range(0, 7))
      0: v = 32'h8000_0000;
      1: v = 32'h7fff_ffff;
      2: v = '0;
      3: v = '1;
      default: v = $urandom();
    endcase
    return v;
  endfunction

  // operation mix with a tunable share of inserts
  function automatic logic [bdq_pkg::OpW-1:0] pick_op(int unsigned push_pct);
    int unsigned r;
    logic [bdq_pkg::OpW-1:0] op;
    r = $urandom_range(0, 99);
    if (r < 4) op = bdq_pkg::OpW'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST));
    else if (r < 9) op = bdq_pkg::OP_QUERY;
    else if (r < 9 + push_pct)
      op = $urandom_range(0, 1) ? bdq_pkg::OP_INS_FRONT : bdq_pkg::OP_INS_BACK;
    else op = $urandom_range(0, 1) ? bdq_pkg::OP_DEL_FRONT : bdq_pkg::OP_DEL_BACK;
    return op;
  endfunction

  // stimulus
  initial begin
    int unsigned              sent;
    int unsigned              phase_len;
    int unsigned              push_pct;
    logic [bdq_pkg::CntW-1:0] cap;
    sent = 0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty deque at reset capacity: refused deletes, head wrapping below zero
    send_word(bdq_pkg::OP_QUERY, 32'h0);
    send_word(bdq_pkg::OP_DEL_FRONT, 32'hffff_ffff);
    send_word(bdq_pkg::OP_DEL_BACK, 32'h0);
    send_word(bdq_pkg::OP_INS_FRONT, 32'h7fff_ffff);
    send_word(bdq_pkg::OP_INS_BACK, 32'h8000_0000);
    send_word(bdq_pkg::OP_INS_FRONT, 32'h0);
    send_word(bdq_pkg::OP_INS_BACK, 32'hffff_ffff);
    for (int c = OP_SPARE_FIRST; c <= OP_SPARE_LAST; c++) begin
      send_word(bdq_pkg::OpW'(c), $urandom());
    end
    send_word(bdq_pkg::OP_DEL_FRONT, $urandom());
    send_word(bdq_pkg::OP_DEL_BACK, $urandom());
    send_word(bdq_pkg::OP_DEL_FRONT, $urandom());
    send_word(bdq_pkg::OP_DEL_BACK, $urandom());
    send_word(bdq_pkg::OP_DEL_FRONT, $urandom());

    // capacity of one
    write_capacity(11'd1);
    send_word(bdq_pkg::OP_INS_BACK, 32'h1234_5678);
    send_word(bdq_pkg::OP_INS_FRONT, 32'h5555_aaaa);
    send_word(bdq_pkg::OP_QUERY, 32'h0);

    // capacity of zero: inserts refused, empty and full together
    write_capacity(11'd0);
    send_word(bdq_pkg::OP_QUERY, 32'h0);
    send_word(bdq_pkg::OP_INS_FRONT, 32'h0bad_cafe);
    send_word(bdq_pkg::OP_DEL_FRONT, 32'h0);
    send_word(bdq_pkg::OP_INS_BACK, 32'h0bad_cafe);

    // capacity lowered under the current count
    write_capacity(11'd8);
    repeat (5) send_word(bdq_pkg::OP_INS_BACK, $urandom());
    write_capacity(11'd2);
    send_word(bdq_pkg::OP_INS_FRONT, $urandom());
    send_word(bdq_pkg::OP_DEL_BACK, $urandom());
    send_word(bdq_pkg::OP_DEL_FRONT, $urandom());
    send_word(bdq_pkg::OP_DEL_FRONT, $urandom());
    send_word(bdq_pkg::OP_INS_BACK, $urandom());

    // capacity above the ring depth: back-to-back inserts at both ends, then drain
    write_capacity(CAP_ALL_ONES);
    steady_send = 1'b1;
    repeat (16) begin
      send_word($urandom_range(0, 1) ? bdq_pkg::OP_INS_FRONT : bdq_pkg::OP_INS_BACK,
                $urandom());
    end
    send_word(bdq_pkg::OP_QUERY, $urandom());
    while (tracker.held != 0) begin
      send_word($urandom_range(0, 1) ? bdq_pkg::OP_DEL_FRONT : bdq_pkg::OP_DEL_BACK,
                $urandom());
    end
    steady_send = 1'b0;

    // random phases, each with its own capacity and operation mix
    while (sent < RANDOM_WORDS) begin
      case ($urandom_range(0, 7))
        0: cap = '0;
        1: cap = 11'd1;
        2: cap = bdq_pkg::CntW'($urandom_range(2, 4));
        3: cap = bdq_pkg::CntW'($urandom_range(5, 24));
        4: cap = bdq_pkg::CntW'((tracker.held > 1) ? tracker.held / 2 : 1);
        5: cap = bdq_pkg::CapReset;
        6: cap = bdq_pkg::CntW'($urandom_range(RING_DEPTH + 1, CAP_ALL_ONES));
        default: cap = bdq_pkg::CntW'($urandom_range(0, CAP_ALL_ONES));
      endcase
      write_capacity(cap);
      steady_send = ($urandom_range(0, 3) == 0);
      phase_len   = $urandom_range(20, 60);
      push_pct    = $urandom_range(15, 75);
      repeat (phase_len) begin
        send_word(pick_op(push_pct), pick_value());
        sent++;
      end
    end

    // let every outstanding result come back
    in_valid_i <= 1'b0;
    while (tracker.expected_views.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("run: %0d words sent, %0d results checked, %0d operations refused",
             tracker.words, tracker.checked, tracker.refused);
    $display("run: capacities from 0 to %0d, deepest occupancy %0d entries",
             CAP_ALL_ONES, tracker.peak);
    if (tracker.errors == 0 && tracker.expected_views.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
